[rtl/order_statistic_multiset_defines.svh]
// Assertion macros for the order statistic multiset checker.
// Used by osm_checker; no other dependencies.
`ifndef ORDER_STATISTIC_MULTISET_DEFINES_SVH
`define ORDER_STATISTIC_MULTISET_DEFINES_SVH

// same-cycle implication
`define OSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/osm_pkg.sv]
// Shared constants for the order statistic multiset.
// No dependencies.
`default_nettype none
package osm_pkg;
    localparam int CMD_W  = 3;
    localparam int OPND_W = 32;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RANK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SELECT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PRED   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SUCC   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
endpackage
`default_nettype wire

[rtl/osm_req_if.sv]
// Request channel of the order statistic multiset.
// Depends on osm_pkg.
`default_nettype none
interface osm_req_if;
    import osm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [OPND_W-1:0] operand;

    modport source (output valid, command, operand, input ready);
    modport sink   (input valid, command, operand, output ready);
endinterface
`default_nettype wire

[rtl/osm_rsp_if.sv]
// Response channel of the order statistic multiset.
// Depends on osm_pkg; CNT_W must be $clog2(CAPACITY+1).
`default_nettype none
interface osm_rsp_if #(parameter int CNT_W = 11);
    import osm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        stored_count;

    modport source (output valid, result_value, status, stored_count, input ready);
    modport sink   (input valid, result_value, status, stored_count, output ready);
endinterface
`default_nettype wire

[rtl/order_statistic_multiset.sv]
// Order statistic multiset: sorted keys in one synchronous memory.
// Depends on osm_pkg, osm_req_if, osm_rsp_if.
//
// One request at a time. Rank, predecessor, successor, insert and delete run a
// binary search over the keys, one memory read (S_SRCH) and one compare (S_SCMP)
// per probe; predecessor, successor, select and delete then fetch one key
// (S_FETCH, S_FDATA), and S_DONE posts the response; select skips the search.
// Insert and delete add a shift of the moved entries one at a time (n-pos for
// insert, n-pos-1 for delete). The key memory has a single read port. A
// pending response waits in an output register; the next request is taken
// once the current one has been posted there.
`default_nettype none
module order_statistic_multiset #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire            clk,
    input  wire            rst_n,
    osm_req_if.sink        req,
    osm_rsp_if.source      rsp
);
    import osm_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = (KEY_BITS > CNT_W) ? KEY_BITS : CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_FDATA = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_LAST  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic signed [KEY_BITS-1:0] mem [CAPACITY];
    logic signed [KEY_BITS-1:0] rd_data;
    logic [AW-1:0]              raddr;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic signed [KEY_BITS-1:0] wdata;

    logic [3:0]                 state_reg, state_next;
    logic [CMD_W-1:0]           cmd_reg, cmd_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]           lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [AW-1:0]              fetch_reg, fetch_next;
    logic                       pend_reg, pend_next;
    logic [AW-1:0]              pend_addr_reg, pend_addr_next;
    logic [VAL_W-1:0]           val_reg, val_next;
    logic [STAT_W-1:0]          st_reg, st_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       ov_reg, ov_next;
    logic [VAL_W-1:0]           oval_reg, oval_next;
    logic [STAT_W-1:0]          ost_reg, ost_next;
    logic [CNT_W-1:0]           ocnt_reg, ocnt_next;

    logic signed [63:0]         opnd64;
    logic signed [KEY_BITS-1:0] x_in;
    logic [CW-1:0]              xz, cz;
    logic [CNT_W-1:0]           mid, idx_dec, idx_inc, lo_inc;
    logic                       or_equal, go_right;
    logic signed [63:0]         rd64;
    logic [63:0]                rank64;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data <= mem[raddr];
    end

    assign opnd64   = 64'(req.operand);
    assign x_in     = opnd64[KEY_BITS-1:0];
    assign xz       = CW'($unsigned(x_in));
    assign cz       = CW'(count_reg);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec  = idx_reg - 1'b1;
    assign idx_inc  = idx_reg + 1'b1;
    assign lo_inc   = lo_reg + 1'b1;
    assign or_equal = (cmd_reg == CMD_INSERT) || (cmd_reg == CMD_SUCC);
    assign go_right = or_equal ? !(key_reg < rd_data) : (rd_data < key_reg);
    assign rd64     = 64'(rd_data);
    assign rank64   = 64'(lo_reg) + 64'd1;

    assign we    = pend_reg || (state_reg == S_LAST && cmd_reg == CMD_INSERT);
    assign waddr = pend_reg ? pend_addr_reg : lo_reg[AW-1:0];
    assign wdata = pend_reg ? rd_data : key_reg;

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = ov_reg;
    assign rsp.result_value = oval_reg;
    assign rsp.status       = ost_reg;
    assign rsp.stored_count = ocnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        fetch_next     = fetch_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        count_next     = count_reg;
        ov_next        = ov_reg && !rsp.ready;
        oval_next      = oval_reg;
        ost_next       = ost_reg;
        ocnt_next      = ocnt_reg;
        raddr          = fetch_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next = req.command;
                    key_next = x_in;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    val_next = '0;
                    st_next  = ST_OK;
                    priority case (req.command)
                        CMD_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_SRCH;
                        end
                        CMD_DELETE, CMD_RANK, CMD_PRED, CMD_SUCC:
                            state_next = S_SRCH;
                        CMD_SELECT:
                        begin
                            if (!x_in[KEY_BITS-1] && xz != '0 && xz <= cz)
                            begin
                                fetch_next = AW'(xz - 1'b1);
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            st_next    = ST_NOT_FOUND;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    raddr      = mid[AW-1:0];
                    state_next = S_SCMP;
                end
                else
                begin
                    priority case (cmd_reg)
                        CMD_INSERT:
                        begin
                            idx_next   = count_reg;
                            state_next = S_SHIFT;
                        end
                        CMD_DELETE, CMD_SUCC:
                        begin
                            if (lo_reg >= count_reg)
                            begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                fetch_next = lo_reg[AW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        CMD_PRED:
                        begin
                            if (lo_reg == '0)
                            begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                fetch_next = AW'(lo_reg - 1'b1);
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            val_next   = rank64[VAL_W-1:0];
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCMP:
            begin
                if (go_right)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
                state_next = S_SRCH;
            end
            S_FETCH:
                state_next = S_FDATA;
            S_FDATA:
            begin
                if (cmd_reg == CMD_DELETE)
                begin
                    if (rd_data == key_reg)
                    begin
                        idx_next   = lo_inc;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    val_next   = rd64[VAL_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (idx_reg > lo_reg)
                    begin
                        raddr          = idx_dec[AW-1:0];
                        pend_next      = 1'b1;
                        pend_addr_next = idx_reg[AW-1:0];
                        idx_next       = idx_dec;
                    end
                    else
                        state_next = S_LAST;
                end
                else
                begin
                    if (idx_reg < count_reg)
                    begin
                        raddr          = idx_reg[AW-1:0];
                        pend_next      = 1'b1;
                        pend_addr_next = idx_dec[AW-1:0];
                        idx_next       = idx_inc;
                    end
                    else
                        state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!pend_reg)
                begin
                    if (cmd_reg == CMD_INSERT)
                        count_next = count_reg + 1'b1;
                    else
                        count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    oval_next  = val_reg;
                    ost_next   = st_reg;
                    ocnt_next  = count_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        idx_reg       <= idx_next;
        fetch_reg     <= fetch_next;
        pend_addr_reg <= pend_addr_next;
        val_reg       <= val_next;
        st_reg        <= st_next;
        oval_reg      <= oval_next;
        ost_reg       <= ost_next;
        ocnt_reg      <= ocnt_next;
    end
endmodule
`default_nettype wire

[rtl/osm_checker.sv]
// Port-level checks for the order statistic multiset, bound to the top level.
// Depends on osm_pkg and order_statistic_multiset_defines.svh.
`include "order_statistic_multiset_defines.svh"
`default_nettype none
module osm_checker #(
    parameter int CAPACITY = 1024,
    parameter int CNT_W    = 11
) (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         rsp_valid,
    input wire                         rsp_ready,
    input wire [osm_pkg::VAL_W-1:0]    rsp_value,
    input wire [osm_pkg::STAT_W-1:0]   rsp_status,
    input wire [CNT_W-1:0]             rsp_count
);
    import osm_pkg::*;

    `OSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_value) && $stable(rsp_status), "response dropped while stalled")
    `OSM_ASSERT_NOW(a_status_code, rsp_valid,
        rsp_status == ST_OK || rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL,
        "bad status code")
    `OSM_ASSERT_NOW(a_fail_zero, rsp_valid && rsp_status != ST_OK,
        rsp_value == '0, "nonzero value on failure")
    `OSM_ASSERT_NOW(a_full_count, rsp_valid && rsp_status == ST_FULL,
        rsp_count == CNT_W'(CAPACITY), "full reported below capacity")
    `OSM_ASSERT_NOW(a_count_range, rsp_valid,
        rsp_count <= CNT_W'(CAPACITY), "count above capacity")
endmodule

bind order_statistic_multiset osm_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_osm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_value  (rsp.result_value),
    .rsp_status (rsp.status),
    .rsp_count  (rsp.stored_count)
);
`default_nettype wire
